[src/blp_pkg.sv]
`timescale 1ns / 1ps
// blp_pkg: shared codes, widths and helpers of the line pixel generator.
// No dependencies.
package blp_pkg;

  localparam int SCREEN_BITS    = 12;
  localparam int PIX_BITS       = 12;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [SCREEN_BITS-1:0] SCREEN_W_RESET = 12'd320;
  localparam logic [SCREEN_BITS-1:0] SCREEN_H_RESET = 12'd240;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_PIXEL  = 2'd2,
    KIND_IDLE   = 2'd3
  } result_kind_e;

  // two's complement step codes: zero, +1, -1
  typedef enum logic [1:0] {
    DIR_ZERO = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_e;

  // width of one queued command: flags, start point, three decision terms,
  // direction codes, pixel count and colour
  function automatic int cmd_width(int coord_bits, int color_bits);
    return 6 * coord_bits + 16 + color_bits;
  endfunction

endpackage

[src/blp_stream_if.sv]
`timescale 1ns / 1ps
// blp_in_if / blp_out_if: valid/ready channels carrying line requests and results.
// Depends on blp_pkg.
interface blp_in_if #(
  parameter int COORD_BITS = 13,
  parameter int COLOR_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0]        line_color;

  modport source (output valid, action, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, action, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface blp_out_if #(
  parameter int COLOR_BITS = 32
);
  logic                            valid;
  logic                            ready;
  blp_pkg::result_kind_e           result_kind;
  logic [blp_pkg::PIX_BITS-1:0]    pixel_x;
  logic [blp_pkg::PIX_BITS-1:0]    pixel_y;
  logic [COLOR_BITS-1:0]           pixel_color;
  logic                            last_pixel;

  modport source (output valid, result_kind, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, result_kind, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface

[src/blp_front.sv]
`timescale 1ns / 1ps
// blp_front: accepts requests, checks endpoints and prepares the stepper setup.
// Depends on blp_pkg and blp_in_if.
module blp_front #(
  parameter int COORD_BITS = 13,
  parameter int COLOR_BITS = 32
) (
  input  logic [blp_pkg::SCREEN_BITS-1:0] screen_width_i,
  input  logic [blp_pkg::SCREEN_BITS-1:0] screen_height_i,
  blp_in_if.sink                          in_i,
  input  logic                            full_i,
  output logic                            push_o,
  output logic [blp_pkg::cmd_width(COORD_BITS, COLOR_BITS)-1:0] cmd_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 2;
  localparam int CW = (COORD_BITS > blp_pkg::SCREEN_BITS) ? COORD_BITS : blp_pkg::SCREEN_BITS;

  typedef struct packed {
    logic                   is_load;
    logic                   reject;
    logic [CB-1:0]          x0;
    logic [CB-1:0]          y0;
    logic signed [DW-1:0]   decision;
    logic signed [DW-1:0]   inc_straight;
    logic signed [DW-1:0]   inc_diagonal;
    logic [7:0]             dirs;
    logic [CB-1:0]          count;
    logic [COLOR_BITS-1:0]  color;
  } cmd_t;

  cmd_t                 cmd;
  logic signed [DW-1:0] x1, y1, x2, y2;
  logic signed [DW-1:0] dxs, dys, adx, ady;
  logic                 ok_start, ok_end;
  blp_pkg::dir_e        sxc, syc;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign x1 = {{2{in_i.start_x[CB-1]}}, in_i.start_x};
  assign y1 = {{2{in_i.start_y[CB-1]}}, in_i.start_y};
  assign x2 = {{2{in_i.end_x[CB-1]}}, in_i.end_x};
  assign y2 = {{2{in_i.end_y[CB-1]}}, in_i.end_y};

  assign ok_start = !in_i.start_x[CB-1] && !in_i.start_y[CB-1] &&
                    (CW'($unsigned(in_i.start_x)) <= CW'(screen_width_i)) &&
                    (CW'($unsigned(in_i.start_y)) <= CW'(screen_height_i));
  assign ok_end   = !in_i.end_x[CB-1] && !in_i.end_y[CB-1] &&
                    (CW'($unsigned(in_i.end_x)) <= CW'(screen_width_i)) &&
                    (CW'($unsigned(in_i.end_y)) <= CW'(screen_height_i));

  assign dxs = x2 - x1;
  assign dys = y2 - y1;
  assign adx = dxs[DW-1] ? -dxs : dxs;
  assign ady = dys[DW-1] ? -dys : dys;
  assign sxc = (x2 > x1) ? blp_pkg::DIR_POS : blp_pkg::DIR_NEG;
  assign syc = (y2 > y1) ? blp_pkg::DIR_POS : blp_pkg::DIR_NEG;

  always_comb begin
    cmd         = '0;
    cmd.is_load = (in_i.action == blp_pkg::ACT_LOAD);
    cmd.reject  = !(ok_start && ok_end);
    cmd.color   = in_i.line_color;
    if (x1 == x2) begin
      cmd.x0    = CB'(x1);
      cmd.y0    = (y1 < y2) ? CB'(y1) : CB'(y2);
      cmd.count = CB'(ady + DW'(1));
      cmd.dirs  = {blp_pkg::DIR_POS, blp_pkg::DIR_ZERO, blp_pkg::DIR_POS, blp_pkg::DIR_ZERO};
    end else if (y1 == y2) begin
      cmd.x0    = (x1 < x2) ? CB'(x1) : CB'(x2);
      cmd.y0    = CB'(y1);
      cmd.count = CB'(adx + DW'(1));
      cmd.dirs  = {blp_pkg::DIR_ZERO, blp_pkg::DIR_POS, blp_pkg::DIR_ZERO, blp_pkg::DIR_POS};
    end else begin
      cmd.x0 = CB'(x1);
      cmd.y0 = CB'(y1);
      if (adx >= ady) begin
        cmd.count        = CB'(adx + DW'(1));
        cmd.decision     = (ady + ady) - adx;
        cmd.inc_straight = ady + ady;
        cmd.inc_diagonal = (ady - adx) + (ady - adx);
        cmd.dirs         = {syc, sxc, blp_pkg::DIR_ZERO, sxc};
      end else begin
        cmd.count        = CB'(ady + DW'(1));
        cmd.decision     = (adx + adx) - ady;
        cmd.inc_straight = adx + adx;
        cmd.inc_diagonal = (adx - ady) + (adx - ady);
        cmd.dirs         = {syc, sxc, syc, blp_pkg::DIR_ZERO};
      end
    end
  end

  assign cmd_o = cmd;

endmodule

[src/blp_cmd_fifo.sv]
`timescale 1ns / 1ps
// blp_cmd_fifo: short register queue between the front and back parts.
// Depends on blp_pkg.
module blp_cmd_fifo #(
  parameter int WIDTH = 126
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int DEPTH = blp_pkg::CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + NW'(1);
      2'b01:   count_d = count_q - NW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("request pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

endmodule

[src/blp_back.sv]
`timescale 1ns / 1ps
// blp_back: Bresenham stepper state and registered result stage.
// Depends on blp_pkg and blp_out_if.
module blp_back #(
  parameter int COORD_BITS = 13,
  parameter int COLOR_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic [blp_pkg::cmd_width(COORD_BITS, COLOR_BITS)-1:0] cmd_i,
  output logic pop_o,
  blp_out_if.source out_o
);

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 2;

  typedef struct packed {
    logic                   is_load;
    logic                   reject;
    logic [CB-1:0]          x0;
    logic [CB-1:0]          y0;
    logic signed [DW-1:0]   decision;
    logic signed [DW-1:0]   inc_straight;
    logic signed [DW-1:0]   inc_diagonal;
    logic [7:0]             dirs;
    logic [CB-1:0]          count;
    logic [COLOR_BITS-1:0]  color;
  } cmd_t;

  cmd_t                  cmd;
  logic                  take;
  logic                  line_active_q, line_active_d;
  logic [CB-1:0]         cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [DW-1:0]  decision_q, decision_d;
  logic signed [DW-1:0]  inc_straight_q, inc_straight_d;
  logic signed [DW-1:0]  inc_diagonal_q, inc_diagonal_d;
  logic [7:0]            step_dirs_q, step_dirs_d;
  logic [CB-1:0]         pixels_left_q, pixels_left_d;
  logic [COLOR_BITS-1:0] held_color_q, held_color_d;
  logic [1:0]            mv_x, mv_y;

  logic                         out_valid_q;
  blp_pkg::result_kind_e        kind_q, kind_d;
  logic [blp_pkg::PIX_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [COLOR_BITS-1:0]        col_q, col_d;
  logic                         last_q, last_d;

  assign cmd   = cmd_t'(cmd_i);
  assign take  = valid_i && (!out_valid_q || out_o.ready);
  assign pop_o = take;

  // negative decision takes the straight move
  assign mv_x = decision_q[DW-1] ? step_dirs_q[1:0] : step_dirs_q[5:4];
  assign mv_y = decision_q[DW-1] ? step_dirs_q[3:2] : step_dirs_q[7:6];

  always_comb begin
    line_active_d  = line_active_q;
    cur_x_d        = cur_x_q;
    cur_y_d        = cur_y_q;
    decision_d     = decision_q;
    inc_straight_d = inc_straight_q;
    inc_diagonal_d = inc_diagonal_q;
    step_dirs_d    = step_dirs_q;
    pixels_left_d  = pixels_left_q;
    held_color_d   = held_color_q;
    kind_d         = blp_pkg::KIND_IDLE;
    px_d           = '0;
    py_d           = '0;
    col_d          = '0;
    last_d         = 1'b0;
    if (take) begin
      priority if (cmd.is_load) begin
        if (cmd.reject) begin
          kind_d = blp_pkg::KIND_REJECT;
        end else begin
          kind_d         = blp_pkg::KIND_ACCEPT;
          line_active_d  = 1'b1;
          cur_x_d        = cmd.x0;
          cur_y_d        = cmd.y0;
          decision_d     = cmd.decision;
          inc_straight_d = cmd.inc_straight;
          inc_diagonal_d = cmd.inc_diagonal;
          step_dirs_d    = cmd.dirs;
          pixels_left_d  = cmd.count;
          held_color_d   = cmd.color;
        end
      end else if (!line_active_q) begin
        kind_d = blp_pkg::KIND_IDLE;
      end else begin
        kind_d        = blp_pkg::KIND_PIXEL;
        px_d          = blp_pkg::PIX_BITS'(cur_x_q);
        py_d          = blp_pkg::PIX_BITS'(cur_y_q);
        col_d         = held_color_q;
        last_d        = (pixels_left_q == CB'(1));
        decision_d    = decision_q + (decision_q[DW-1] ? inc_straight_q : inc_diagonal_q);
        cur_x_d       = cur_x_q + {{(CB-2){mv_x[1]}}, mv_x};
        cur_y_d       = cur_y_q + {{(CB-2){mv_y[1]}}, mv_y};
        pixels_left_d = pixels_left_q - CB'(1);
        line_active_d = (pixels_left_q != CB'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q  <= 1'b0;
      cur_x_q        <= '0;
      cur_y_q        <= '0;
      decision_q     <= '0;
      inc_straight_q <= '0;
      inc_diagonal_q <= '0;
      step_dirs_q    <= '0;
      pixels_left_q  <= '0;
      held_color_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      line_active_q  <= line_active_d;
      cur_x_q        <= cur_x_d;
      cur_y_q        <= cur_y_d;
      decision_q     <= decision_d;
      inc_straight_q <= inc_straight_d;
      inc_diagonal_q <= inc_diagonal_d;
      step_dirs_q    <= step_dirs_d;
      pixels_left_q  <= pixels_left_d;
      held_color_q   <= held_color_d;
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q <= kind_d;
      px_q   <= px_d;
      py_q   <= py_d;
      col_q  <= col_d;
      last_q <= last_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = kind_q;
  assign out_o.pixel_x     = px_q;
  assign out_o.pixel_y     = py_q;
  assign out_o.pixel_color = col_q;
  assign out_o.last_pixel  = last_q;

  a_active_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q |-> (pixels_left_q != '0)) else $error("active line with no pixels");
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !cmd.is_load && line_active_q && (pixels_left_q == CB'(1)) |=> !line_active_q)
    else $error("line still active after last pixel");
  a_reject_keeps_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cmd.is_load && cmd.reject |=>
      $stable(line_active_q) && $stable(pixels_left_q) && $stable(cur_x_q) && $stable(cur_y_q))
    else $error("rejected load disturbed line state");

endmodule

[src/bresenham_line_pixel_generator.sv]
`timescale 1ns / 1ps
// Bresenham line pixel generator, top level: APB screen registers, front, queue, back.
// Depends on blp_pkg, blp_stream_if, blp_front, blp_cmd_fifo, blp_back.
//
// One request per clock is taken while the queue has room, and each gives exactly one
// result from the result register. A load (action 0) checks both endpoints against
// the screen registers (a coordinate equal to the register passes), answers accept or
// reject, and on accept replaces any line in progress; rejects leave the line alone.
// Each step (action 1) returns the next pixel with its colour and flags the last one;
// a step with no line answers idle. Straight lines run in ascending order, others from
// the first endpoint to the second. The stepper state (decision, position, pixels left)
// is updated as each step is taken; a two-entry queue lets requests keep coming while a
// result waits. Screen registers sit at byte 0 (width) and 4 (height), reset 320 x 240.
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = 13,
  parameter int COLOR_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  blp_in_if.sink                             in_i,
  blp_out_if.source                          out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [blp_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [blp_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [blp_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);

  localparam int CMD_W = blp_pkg::cmd_width(COORD_BITS, COLOR_BITS);

  logic [blp_pkg::SCREEN_BITS-1:0] screen_width_q, screen_height_q;
  logic                            reg_sel;
  logic                            cfg_write;
  logic                            push, full, pop, cmd_valid;
  logic [CMD_W-1:0]                cmd_in, cmd_out;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= blp_pkg::SCREEN_W_RESET;
      screen_height_q <= blp_pkg::SCREEN_H_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        blp_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= pwdata[blp_pkg::SCREEN_BITS-1:0];
        blp_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[blp_pkg::SCREEN_BITS-1:0];
        default:                    screen_width_q  <= screen_width_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      blp_pkg::REG_SCREEN_WIDTH:  prdata = blp_pkg::APB_DATA_BITS'(screen_width_q);
      blp_pkg::REG_SCREEN_HEIGHT: prdata = blp_pkg::APB_DATA_BITS'(screen_height_q);
      default:                    prdata = '0;
    endcase
  end

  blp_front #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_front (
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .in_i            (in_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  blp_cmd_fifo #(
    .WIDTH (CMD_W)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  blp_back #(
    .COORD_BITS (COORD_BITS),
    .COLOR_BITS (COLOR_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_valid),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
